>>> rtl/npq_pkg.sv
// Shared types, codes and default sizes for the nearest point and radius query block.
package npq_pkg;

	localparam int DEF_MAX_POINTS = 32;
	localparam int DEF_COORD_BITS = 16;
	localparam int FIELD_BITS     = 16;
	localparam int DIST_BITS      = 33;
	localparam int RADIUS_BITS    = 16;
	localparam int R2_BITS        = 2 * RADIUS_BITS;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic KIND_NEAREST = 1'b0;
	localparam logic KIND_VISIBLE = 1'b1;

	typedef struct packed {
		logic [1:0]                   action;
		logic signed [FIELD_BITS-1:0] coord_x;
		logic signed [FIELD_BITS-1:0] coord_y;
	} cmd_item_t;

	typedef struct packed {
		logic                         kind;
		logic signed [FIELD_BITS-1:0] point_x;
		logic signed [FIELD_BITS-1:0] point_y;
		logic [DIST_BITS-1:0]         dist_sq;
		logic                         last;
	} res_item_t;

	// travels with each point through the distance pipeline
	typedef struct packed {
		logic live;   // entry lies below the fill count
		logic tail;   // final entry of the ring sweep
	} scan_tag_t;

endpackage

>>> rtl/nearest_point_and_radius_query.sv
// Nearest point and radius query: top level with point ring, scan sequencer and result queue.
//
// The block keeps up to MAX_POINTS points in a ring of cells. A clear or append command is
// taken without a stall while no query runs; an append to a full ring is dropped. A query
// sweeps the ring twice, one point per cycle while the output does not stall, through a
// three-stage squared distance pipeline: the first sweep finds the nearest stored point
// (earliest wins a tie), the second reports every stored point whose squared distance from
// that nearest point is below visible_radius squared, in store order. The first result of a
// query is the nearest point (kind 0) with its squared distance from the query point; with an
// empty store it is (0,0) at all ones. The next command is taken once the ring has rotated
// once per sweep and the pipeline has drained after each sweep, with an extra flush state when
// the store is full and its last point is visible. Any cycle in which a result waits on a
// stalled output freezes the sweep. New commands are taken only while no query is in progress;
// the final result of a query may still wait in the output register. The result queue holds
// one result back so that its last flag is known before it goes out. The ring needs no
// clearing: only entries below the fill count are ever used. radius_we writes visible_radius;
// its square is kept internally.
module nearest_point_and_radius_query import npq_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command channel
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  cmd_item_t              cmd,
	// result channel
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_item_t              res,
	// visible_radius register
	input  logic                   radius_we,
	input  logic [RADIUS_BITS-1:0] radius_wdata
);

	localparam int CW   = COORD_BITS;
	localparam int DW   = 2 * CW + 1;
	localparam int IW   = $clog2(MAX_POINTS + 1);
	localparam int CMPW = (DW > R2_BITS) ? DW : R2_BITS;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FEED1 = 6'b000010,
		ST_HOLD1 = 6'b000100,
		ST_FEED2 = 6'b001000,
		ST_HOLD2 = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t state_q;

	logic [IW-1:0]        count_q;
	logic [IW-1:0]        idx_q;
	logic [R2_BITS-1:0]   r2_q;
	logic signed [CW-1:0] qx_q, qy_q;     // query point
	logic signed [CW-1:0] nx_q, ny_q;     // nearest point, reference of second sweep
	logic signed [CW-1:0] best_x_q, best_y_q;
	logic [DW-1:0]        best_d_q;
	logic                 best_valid_q;
	res_item_t            pend_q;
	res_item_t            out_q;
	logic                 out_valid_q;

	logic                 adv;
	logic                 feeding;
	logic                 wr_en;
	logic signed [CW-1:0] cmd_x, cmd_y;
	logic signed [CW-1:0] ring_x [MAX_POINTS];
	logic signed [CW-1:0] ring_y [MAX_POINTS];
	logic signed [CW-1:0] ref_x, ref_y;
	scan_tag_t            feed_tag;
	scan_tag_t            tag_s3;
	logic signed [CW-1:0] px_s3, py_s3;
	logic [DW-1:0]        d_s3;

	logic                 better;
	logic                 take;
	logic                 cand_ok;
	logic signed [CW-1:0] cand_x, cand_y;
	logic [DW-1:0]        cand_d;
	logic                 hit;
	logic                 push_vis;
	logic                 push_fin;
	logic signed [FIELD_BITS-1:0] cand_ox, cand_oy, vis_ox, vis_oy;
	logic [DIST_BITS-1:0]         cand_od, vis_od;
	res_item_t            near_item;
	res_item_t            vis_item;
	res_item_t            pend_fin;

	// whole scan advances only when the output register can take a result
	assign adv     = !(out_valid_q && res_stall);
	assign feeding = state_q inside {ST_FEED1, ST_FEED2};

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	assign wr_en = (state_q == ST_IDLE) && cmd_valid && (cmd.action == ACT_APPEND)
		&& (count_q < IW'(MAX_POINTS));

	// low COORD_BITS of the field as a signed value; a wider coordinate takes the field unsigned
	generate
		if (CW <= FIELD_BITS) begin : g_cin_narrow
			assign cmd_x = cmd.coord_x[CW-1:0];
			assign cmd_y = cmd.coord_y[CW-1:0];
		end else begin : g_cin_wide
			assign cmd_x = {{(CW-FIELD_BITS){1'b0}}, cmd.coord_x};
			assign cmd_y = {{(CW-FIELD_BITS){1'b0}}, cmd.coord_y};
		end
	endgenerate

	// ring: cell i hands its point to cell i-1, cell 0 is the head
	generate
		for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
			npq_cell #(
				.CW  (CW),
				.IW  (IW),
				.IDX (i)
			) u_cell (
				.clk    (clk),
				.wr_en  (wr_en),
				.wr_idx (count_q),
				.wr_x   (cmd_x),
				.wr_y   (cmd_y),
				.shift  (feeding && adv),
				.nxt_x  (ring_x[(i + 1) % MAX_POINTS]),
				.nxt_y  (ring_y[(i + 1) % MAX_POINTS]),
				.x      (ring_x[i]),
				.y      (ring_y[i])
			);
		end
	endgenerate

	assign ref_x = (state_q == ST_FEED2) ? nx_q : qx_q;
	assign ref_y = (state_q == ST_FEED2) ? ny_q : qy_q;

	assign feed_tag.live = feeding && (idx_q < count_q);
	assign feed_tag.tail = feeding && (idx_q == IW'(MAX_POINTS - 1));

	npq_dist #(
		.CW (CW)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.tag     (feed_tag),
		.ax      (ref_x),
		.ay      (ref_y),
		.bx      (ring_x[0]),
		.by      (ring_y[0]),
		.tag_out (tag_s3),
		.px_out  (px_s3),
		.py_out  (py_s3),
		.dsq     (d_s3)
	);

	// first sweep: running minimum, strict less-than keeps the earliest point
	assign better  = !best_valid_q || (d_s3 < best_d_q);
	assign take    = tag_s3.live && better;
	assign cand_ok = take || best_valid_q;
	assign cand_x  = take ? px_s3 : best_x_q;
	assign cand_y  = take ? py_s3 : best_y_q;
	assign cand_d  = take ? d_s3  : best_d_q;

	// second sweep: exact compare against radius squared
	assign hit = tag_s3.live && (CMPW'(d_s3) < CMPW'(r2_q));

	// a hit pushes the held result out; the sweep end sends the held one as final
	assign push_vis = adv && hit && (state_q inside {ST_FEED2, ST_HOLD2});
	assign push_fin = adv && !push_vis
		&& (((state_q == ST_HOLD2) && tag_s3.tail) || (state_q == ST_FLUSH));

	// coordinates out as 16-bit two's complement
	generate
		if (CW < FIELD_BITS) begin : g_cout_narrow
			assign cand_ox = {{(FIELD_BITS-CW){cand_x[CW-1]}}, cand_x};
			assign cand_oy = {{(FIELD_BITS-CW){cand_y[CW-1]}}, cand_y};
			assign vis_ox  = {{(FIELD_BITS-CW){px_s3[CW-1]}}, px_s3};
			assign vis_oy  = {{(FIELD_BITS-CW){py_s3[CW-1]}}, py_s3};
		end else begin : g_cout_wide
			assign cand_ox = cand_x[FIELD_BITS-1:0];
			assign cand_oy = cand_y[FIELD_BITS-1:0];
			assign vis_ox  = px_s3[FIELD_BITS-1:0];
			assign vis_oy  = py_s3[FIELD_BITS-1:0];
		end
	endgenerate

	// distance out, saturated to all ones when too wide
	generate
		if (DW < DIST_BITS) begin : g_dout_narrow
			assign cand_od = {{(DIST_BITS-DW){1'b0}}, cand_d};
			assign vis_od  = {{(DIST_BITS-DW){1'b0}}, d_s3};
		end else if (DW == DIST_BITS) begin : g_dout_exact
			assign cand_od = cand_d;
			assign vis_od  = d_s3;
		end else begin : g_dout_wide
			assign cand_od = (|cand_d[DW-1:DIST_BITS]) ? '1 : cand_d[DIST_BITS-1:0];
			assign vis_od  = (|d_s3[DW-1:DIST_BITS]) ? '1 : d_s3[DIST_BITS-1:0];
		end
	endgenerate

	always_comb begin
		near_item.kind    = KIND_NEAREST;
		near_item.point_x = cand_ok ? cand_ox : '0;
		near_item.point_y = cand_ok ? cand_oy : '0;
		near_item.dist_sq = cand_ok ? cand_od : '1;   // empty store
		near_item.last    = 1'b0;
		vis_item.kind     = KIND_VISIBLE;
		vis_item.point_x  = vis_ox;
		vis_item.point_y  = vis_oy;
		vis_item.dist_sq  = vis_od;
		vis_item.last     = 1'b0;
		pend_fin          = pend_q;
		pend_fin.last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			r2_q         <= '0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (radius_we) begin
				r2_q <= R2_BITS'(radius_wdata) * R2_BITS'(radius_wdata);
			end
			if (push_vis || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.action)
							ACT_CLEAR: begin
								count_q <= '0;
							end
							ACT_APPEND: begin
								if (wr_en) begin
									count_q <= count_q + IW'(1);
								end
							end
							ACT_QUERY: begin
								best_valid_q <= 1'b0;
								idx_q        <= '0;
								state_q      <= ST_FEED1;
							end
							default: ;
						endcase
					end
				end
				ST_FEED1, ST_FEED2: begin
					if (adv) begin
						if (idx_q == IW'(MAX_POINTS - 1)) begin
							idx_q   <= '0;
							state_q <= (state_q == ST_FEED1) ? ST_HOLD1 : ST_HOLD2;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_HOLD1: begin
					if (adv && tag_s3.tail) begin
						state_q <= ST_FEED2;
					end
				end
				ST_HOLD2: begin
					if (adv && tag_s3.tail) begin
						state_q <= hit ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// first sweep results
			if (adv && tag_s3.live && (state_q inside {ST_FEED1, ST_HOLD1})) begin
				best_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && cmd_valid && (cmd.action == ACT_QUERY)) begin
			qx_q <= cmd_x;
			qy_q <= cmd_y;
		end
		if (adv && take && (state_q inside {ST_FEED1, ST_HOLD1})) begin
			best_x_q <= px_s3;
			best_y_q <= py_s3;
			best_d_q <= d_s3;
		end
		if (adv && tag_s3.tail && (state_q == ST_HOLD1)) begin
			pend_q <= near_item;
			nx_q   <= cand_x;
			ny_q   <= cand_y;
		end
		if (push_vis) begin
			out_q  <= pend_q;
			pend_q <= vis_item;
		end else if (push_fin) begin
			out_q <= pend_fin;
		end
	end

endmodule

>>> rtl/npq_cell.sv
// One storage cell of the point ring: holds a point, loads on append, passes it on when rotating.
module npq_cell import npq_pkg::*; #(
	parameter int CW  = DEF_COORD_BITS,
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_idx,
	input  logic signed [CW-1:0] wr_x,
	input  logic signed [CW-1:0] wr_y,
	input  logic                 shift,
	input  logic signed [CW-1:0] nxt_x,
	input  logic signed [CW-1:0] nxt_y,
	output logic signed [CW-1:0] x,
	output logic signed [CW-1:0] y
);

	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IW'(IDX))) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end else if (shift) begin
			x_q <= nxt_x;
			y_q <= nxt_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

>>> rtl/npq_dist.sv
// Three-stage squared distance pipeline: absolute differences, squares, sum.
module npq_dist import npq_pkg::*; #(
	parameter int CW = DEF_COORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  scan_tag_t            tag,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	output scan_tag_t            tag_out,
	output logic signed [CW-1:0] px_out,
	output logic signed [CW-1:0] py_out,
	output logic [2*CW:0]        dsq
);

	logic signed [CW:0] ddx, ddy, ndx, ndy;
	logic [CW-1:0]      adx, ady;

	scan_tag_t            tag_s1, tag_s2, tag_s3;
	logic signed [CW-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic [CW-1:0]        dx_s1, dy_s1;
	logic [2*CW-1:0]      sqx_s2, sqy_s2;
	logic [2*CW:0]        d_s3;

	assign ddx = {ax[CW-1], ax} - {bx[CW-1], bx};
	assign ddy = {ay[CW-1], ay} - {by[CW-1], by};
	assign ndx = -ddx;
	assign ndy = -ddy;
	// difference magnitude always fits CW bits
	assign adx = ddx[CW] ? ndx[CW-1:0] : ddx[CW-1:0];
	assign ady = ddy[CW] ? ndy[CW-1:0] : ddy[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= adx;
			dy_s1  <= ady;
			px_s1  <= bx;
			py_s1  <= by;
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			d_s3   <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			px_s3  <= px_s2;
			py_s3  <= py_s2;
		end
	end

	assign tag_out = tag_s3;
	assign px_out  = px_s3;
	assign py_out  = py_s3;
	assign dsq     = d_s3;

endmodule

>>> tb/nearest_point_and_radius_query_tb.sv
// Self-checking testbench for the nearest point and radius query block.
`timescale 1ns / 1ps

module nearest_point_and_radius_query_tb;
	import npq_pkg::*;

	localparam int MAX_POINTS    = DEF_MAX_POINTS;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD     = 600;     // receiver hold-off, well past one query
	localparam int CYCLE_LIMIT   = 500000;

	// the package has no name for the spare action code
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cmd_valid    = 1'b0;
	logic                   cmd_stall;
	cmd_item_t              cmd          = '0;
	logic                   res_valid;
	logic                   res_stall    = 1'b0;
	res_item_t              res;
	logic                   radius_we    = 1'b0;
	logic [RADIUS_BITS-1:0] radius_wdata = '0;

	nearest_point_and_radius_query #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(DEF_COORD_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.radius_we   (radius_we),
		.radius_wdata(radius_wdata)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the block: point store, fill count and radius
	// ------------------------------------------------------------------
	int shadow_x [MAX_POINTS];
	int shadow_y [MAX_POINTS];
	int shadow_count  = 0;
	int shadow_radius = 0;

	cmd_item_t pending_cmds[$];       // commands not yet offered
	res_item_t expected_results[$];   // results predicted, not yet seen

	int errors          = 0;
	int n_queued        = 0;
	int n_transfers     = 0;
	int n_queries       = 0;
	int n_drops         = 0;
	int n_results       = 0;
	int most_results    = 0;
	int n_radius_writes = 0;
	int cycle_count     = 0;

	// hold-off handshake between the stimulus and the receiver
	int hold_requests = 0;
	int hold_served   = 0;

	function automatic longint sq_dist(int ax, int ay, int bx, int by);
		longint dx;
		longint dy;
		dx = ax - bx;
		dy = ay - by;
		return dx * dx + dy * dy;
	endfunction

	// Update the shadow with one accepted command and queue the results it causes.
	task automatic apply_command(cmd_item_t c);
		int        qx;
		int        qy;
		int        nx;
		int        ny;
		int        best;
		int        n_out;
		longint    d;
		longint    best_d;
		longint    r2;
		res_item_t r;
		qx = $signed(c.coord_x);
		qy = $signed(c.coord_y);
		case (c.action)
			ACT_CLEAR: begin
				shadow_count = 0;
			end
			ACT_APPEND: begin
				if (shadow_count < MAX_POINTS) begin
					shadow_x[shadow_count] = qx;
					shadow_y[shadow_count] = qy;
					shadow_count++;
				end else begin
					n_drops++;   // full store: point is lost
				end
			end
			ACT_QUERY: begin
				n_queries++;
				if (shadow_count == 0) begin
					// empty store: origin at "no distance"
					r.kind    = KIND_NEAREST;
					r.point_x = '0;
					r.point_y = '0;
					r.dist_sq = '1;
					r.last    = 1'b1;
					expected_results = {expected_results, r};
					n_out = 1;
				end else begin
					// first sweep: strict less-than keeps the earliest on a tie
					best   = 0;
					best_d = sq_dist(qx, qy, shadow_x[0], shadow_y[0]);
					for (int i = 1; i < shadow_count; i++) begin
						d = sq_dist(qx, qy, shadow_x[i], shadow_y[i]);
						if (d < best_d) begin
							best_d = d;
							best   = i;
						end
					end
					nx = shadow_x[best];
					ny = shadow_y[best];
					r.kind    = KIND_NEAREST;
					r.point_x = nx[FIELD_BITS-1:0];
					r.point_y = ny[FIELD_BITS-1:0];
					r.dist_sq = best_d[DIST_BITS-1:0];
					r.last    = 1'b1;
					expected_results = {expected_results, r};
					n_out = 1;
					// second sweep: radius filter around the nearest point, store order
					r2 = longint'(shadow_radius) * longint'(shadow_radius);
					for (int i = 0; i < shadow_count; i++) begin
						d = sq_dist(nx, ny, shadow_x[i], shadow_y[i]);
						if (d < r2) begin
							expected_results[expected_results.size() - 1].last = 1'b0;
							r.kind    = KIND_VISIBLE;
							r.point_x = shadow_x[i][FIELD_BITS-1:0];
							r.point_y = shadow_y[i][FIELD_BITS-1:0];
							r.dist_sq = d[DIST_BITS-1:0];
							r.last    = 1'b1;
							expected_results = {expected_results, r};
							n_out++;
						end
					end
				end
				if (n_out > most_results) begin
					most_results = n_out;
				end
			end
			default: ;   // spare code: ignored
		endcase
	endtask

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t result %0d: %s", $realtime, n_results, msg);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length, random gaps in between
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				apply_command(cmd);
				n_transfers++;
			end
			// slot is free when nothing is offered or the offer went through
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd       <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						// a quarter of bursts run straight into the next one
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern that switches mode, plus requested long hold-offs
	// ------------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          hold_left  = 0;
	int          stall_tick = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = LONG_HOLD - 1;
			res_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			stall_tick++;
			case (stall_mode)
				STALL_NONE:     res_stall <= 1'b0;
				STALL_SPARSE:   res_stall <= ($urandom_range(0, 3) == 0);
				STALL_PERIODIC: res_stall <= (stall_tick % 5 < 2);
				default:        res_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every result transfer against the oldest prediction
	// ------------------------------------------------------------------
	res_item_t want;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d (%0d,%0d) d=%0h",
					res.kind, res.point_x, res.point_y, res.dist_sq));
			end else begin
				want = expected_results.pop_front();
				if (res.kind !== want.kind)
					report_mismatch($sformatf("kind %0b, expected %0b", res.kind, want.kind));
				if (res.point_x !== want.point_x)
					report_mismatch($sformatf("point_x %0d, expected %0d",
						res.point_x, want.point_x));
				if (res.point_y !== want.point_y)
					report_mismatch($sformatf("point_y %0d, expected %0d",
						res.point_y, want.point_y));
				if (res.dist_sq !== want.dist_sq)
					report_mismatch($sformatf("dist_sq %0h, expected %0h",
						res.dist_sq, want.dist_sq));
				if (res.last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", res.last, want.last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still awaited",
				cycle_count, expected_results.size());
			$display("** nearest_point_and_radius_query: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_cmd(logic [1:0] act, logic [15:0] x, logic [15:0] y);
		cmd_item_t c;
		c.action  = act;
		c.coord_x = x;
		c.coord_y = y;
		pending_cmds = {pending_cmds, c};
		n_queued++;
	endtask

	// mostly near a center, now and then anywhere; wraps at the field width
	function automatic logic [15:0] coord_near(int center, int spread);
		int v;
		if ($urandom_range(0, 7) == 0) begin
			return 16'($urandom);
		end
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		return v[15:0];
	endfunction

	// one well-formed session: usually clear, a run of appends, a few queries
	task automatic queue_session(int spread, bit fill_store);
		int cx;
		int cy;
		int n_app;
		int n_q;
		cx = int'($urandom_range(0, 65535)) - 32768;
		cy = int'($urandom_range(0, 65535)) - 32768;
		if (fill_store || $urandom_range(0, 4) != 0) begin
			queue_cmd(ACT_CLEAR, 16'($urandom), 16'($urandom));
		end
		if (fill_store) begin
			n_app = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 3);
		end else if ($urandom_range(0, 9) == 0) begin
			n_app = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 2);
		end else begin
			n_app = $urandom_range(0, 8);
		end
		for (int i = 0; i < n_app; i++) begin
			queue_cmd(ACT_APPEND, coord_near(cx, spread), coord_near(cy, spread));
			if ($urandom_range(0, 9) == 0) begin
				queue_cmd(ACT_UNUSED, 16'($urandom), 16'($urandom));
			end
		end
		n_q = $urandom_range(1, 4);
		for (int i = 0; i < n_q; i++) begin
			queue_cmd(ACT_QUERY, coord_near(cx, 2 * spread), coord_near(cy, 2 * spread));
		end
	endtask

	// wait until every command went through and every result came back
	task automatic wait_idle();
		do begin
			@(posedge clk);
		end while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_BITS-1:0] value);
		@(posedge clk);
		radius_we     <= 1'b1;
		radius_wdata  <= value;
		shadow_radius = value;
		n_radius_writes++;
		@(posedge clk);
		radius_we <= 1'b0;
	endtask

	int phase_radius [5];
	int spread;
	int start_count;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: radius still at its reset value of zero.
		queue_cmd(ACT_QUERY, 16'sd0, 16'sd0);              // empty store
		queue_cmd(ACT_UNUSED, 16'hFFFF, 16'hFFFF);          // spare code, ignored
		queue_cmd(ACT_APPEND, -16'sd32768, -16'sd32768);    // the four corners
		queue_cmd(ACT_APPEND, 16'sd32767, -16'sd32768);
		queue_cmd(ACT_APPEND, 16'sd32767, 16'sd32767);
		queue_cmd(ACT_APPEND, -16'sd32768, 16'sd32767);
		queue_cmd(ACT_APPEND, 16'sd0, 16'sd0);              // duplicate pair for a tie
		queue_cmd(ACT_APPEND, 16'sd0, 16'sd0);
		queue_cmd(ACT_QUERY, -16'sd32768, -16'sd32768);     // zero radius: nearest only
		queue_cmd(ACT_QUERY, 16'sd5, -16'sd3);              // tie, earlier copy wins
		wait_idle();

		// Widest radius: corner to corner sits exactly on the bound, so is not visible.
		write_radius(16'hFFFF);
		queue_cmd(ACT_QUERY, 16'sd32767, 16'sd32767);
		queue_cmd(ACT_QUERY, 16'sd1, 16'sd1);
		queue_cmd(ACT_QUERY, -16'sd32768, 16'sd32767);
		wait_idle();

		// Radius one: only exact copies of the nearest point count.
		write_radius(16'd1);
		queue_cmd(ACT_QUERY, 16'sd0, 16'sd1);
		queue_cmd(ACT_CLEAR, 16'sd0, 16'sd0);
		queue_cmd(ACT_QUERY, 16'sd100, 16'sd100);           // empty again after clear
		queue_cmd(ACT_APPEND, 16'sd7, 16'sd7);
		queue_cmd(ACT_QUERY, -16'sd32768, -16'sd32768);
		wait_idle();

		// Random phases, one radius each.
		phase_radius[0] = 0;
		phase_radius[1] = $urandom_range(2, 400);
		phase_radius[2] = 65535;
		phase_radius[3] = $urandom_range(400, 20000);
		phase_radius[4] = $urandom_range(0, 65535);
		for (int p = 0; p < 5; p++) begin
			write_radius(phase_radius[p][RADIUS_BITS-1:0]);
			spread = (phase_radius[p] < 8) ? 8 : phase_radius[p];
			start_count = n_queued;
			if (p == 2) begin
				// full store at the widest radius with the receiver held off:
				// results back up and the command side has to stall
				hold_requests <= hold_requests + 1;
				queue_session(spread, 1'b1);
			end
			while (n_queued - start_count < 8) begin
				queue_session(spread, 1'b0);
			end
			wait_idle();   // sender waits for the last result before the next write
		end

		$display("Run covered %0d command transfers, %0d queries and %0d appends dropped on a full store,",
			n_transfers, n_queries, n_drops);
		$display("with %0d results checked over %0d radius settings; the longest query gave %0d results.",
			n_results, n_radius_writes, most_results);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("** nearest_point_and_radius_query: PASSED **");
		end else begin
			$display("** nearest_point_and_radius_query: FAILED **");
		end
		$finish;
	end

endmodule
